### src/assert_macros.svh
// Assertion macros shared by the bank controller RTL.
// No dependencies; include before the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with async active-low reset disable and a message.
`define CBC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with a generic message.
`define CBC_ASSERT(lbl, clk, rst_n, prop) \
	`CBC_ASSERT_MSG(lbl, clk, rst_n, prop, "cartridge bank controller check failed")

`endif

### src/cbc_pkg.sv
// Shared types, codes and helpers for the cartridge bank controller.
// No dependencies.
package cbc_pkg;

	// mapper kinds
	localparam logic [2:0] MT_ROM  = 3'd0;
	localparam logic [2:0] MT_MBC1 = 3'd1;
	localparam logic [2:0] MT_MBC2 = 3'd2;
	localparam logic [2:0] MT_MBC3 = 3'd3;
	localparam logic [2:0] MT_MBC5 = 3'd4;

	// result target codes
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;
	localparam logic [1:0] TGT_HERE = 2'd3;

	localparam logic [7:0] OPEN_BUS  = 8'hFF;
	localparam logic [7:0] MBC2_MASK = 8'hF0;

	localparam int DEFAULT_EXT_RAM_BYTES = 32768;

	typedef struct packed {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [2:0]      kind;
		logic [8:0]      rom_sel;
		logic [3:0]      ram_sel;
		logic            ram_en;
		logic [4:0][7:0] clk_regs;
	} st_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [22:0] rom_address;
		logic [16:0] ram_address;
		logic        ram_write;
		logic [7:0]  ram_write_data;
		logic [7:0]  read_value;
		logic [7:0]  read_or_mask;
	} res_t;

	// clock register pick for banks 8..12 (index is bank low bits)
	function automatic logic [7:0] clk_pick(input logic [4:0][7:0] regs, input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = regs[0];
			3'd1: v = regs[1];
			3'd2: v = regs[2];
			3'd3: v = regs[3];
			3'd4: v = regs[4];
			default: v = OPEN_BUS;
		endcase
		return v;
	endfunction

endpackage

### src/cbc_state.sv
// Mapper state: mapper register, bank selects, enables, clock latch.
// Depends on cbc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cbc_state import cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        fire,
	input  item_t       item,
	input  logic [5:0]  now_seconds,
	input  logic [5:0]  now_minutes,
	input  logic [4:0]  now_hours,
	input  logic [8:0]  now_days,
	output st_t         st
);

	logic [2:0]      mapper_q;
	logic [8:0]      rom_sel_q;
	logic [3:0]      ram_sel_q;
	logic            ram_en_q;
	logic            bank_mode_q;
	logic            latch_armed_q;
	logic [4:0][7:0] clk_regs_q;
	logic [2:0]      kind;
	logic [15:0]     a;
	logic [7:0]      v;
	logic            en_val;
	logic            clk_bank;

	assign kind     = (mapper_q > MT_MBC5) ? MT_ROM : mapper_q;
	assign a        = item.address;
	assign v        = item.write_data;
	assign en_val   = (v[3:0] == 4'hA);
	assign clk_bank = ram_sel_q inside {[4'd8:4'd12]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_q      <= MT_ROM;
			rom_sel_q     <= 9'd1;
			ram_sel_q     <= 4'd0;
			ram_en_q      <= 1'b0;
			bank_mode_q   <= 1'b0;
			latch_armed_q <= 1'b0;
			clk_regs_q    <= '0;
		end else begin
			if (cfg_we) begin
				mapper_q <= cfg_data;
			end
			if (fire && item.mode) begin
				if (a[15:14] == 2'b00) begin
					// 0x0000-0x3FFF: enable / ROM bank low
					if (kind == MT_MBC2) begin
						if (a[8]) begin
							rom_sel_q <= (v[3:0] == 4'h0) ? 9'd1 : {5'd0, v[3:0]};
						end else begin
							ram_en_q <= en_val;
						end
					end else if (!a[13]) begin
						if (kind != MT_ROM) begin
							ram_en_q <= en_val;
						end
					end else begin
						case (kind)
							// low five bits; bank bit 8 drops out
							MT_MBC1: rom_sel_q <= {1'b0, rom_sel_q[7:5],
								(v[4:0] == 5'd0) ? 5'd1 : v[4:0]};
							MT_MBC3: rom_sel_q <= (v[6:0] == 7'd0) ? 9'd1 : {2'd0, v[6:0]};
							MT_MBC5: begin
								if (!a[12]) begin
									rom_sel_q <= {rom_sel_q[8], v};
								end else begin
									rom_sel_q <= {v[0], rom_sel_q[7:0]};
								end
							end
							default: ;
						endcase
					end
				end else if (a[15:13] == 3'b010) begin
					// 0x4000-0x5FFF: RAM bank / ROM bank high
					if (kind == MT_MBC1) begin
						if (!bank_mode_q) begin
							rom_sel_q <= {2'd0, v[1:0], rom_sel_q[4:0]};
						end else begin
							ram_sel_q <= {2'd0, v[1:0]};
						end
					end else if (kind == MT_MBC3 || kind == MT_MBC5) begin
						ram_sel_q <= v[3:0];
					end
				end else if (a[15:13] == 3'b011) begin
					// 0x6000-0x7FFF: banking mode or clock latch
					if (kind == MT_MBC1) begin
						bank_mode_q <= v[0];
					end else if (kind == MT_MBC3) begin
						if (!latch_armed_q && v == 8'h00) begin
							latch_armed_q <= 1'b1;
						end else if (latch_armed_q && v == 8'h01) begin
							clk_regs_q[0] <= {2'd0, now_seconds};
							clk_regs_q[1] <= {2'd0, now_minutes};
							clk_regs_q[2] <= {3'd0, now_hours};
							clk_regs_q[3] <= now_days[7:0];
							clk_regs_q[4] <= {clk_regs_q[4][7], 6'd0, now_days[8]};
							latch_armed_q <= 1'b0;
						end else begin
							latch_armed_q <= 1'b0;
						end
					end
				end else if (a[15:13] == 3'b101 && ram_en_q && kind == MT_MBC3 && clk_bank) begin
					// direct clock register write
					case (ram_sel_q[2:0])
						3'd0: clk_regs_q[0] <= v;
						3'd1: clk_regs_q[1] <= v;
						3'd2: clk_regs_q[2] <= v;
						3'd3: clk_regs_q[3] <= v;
						3'd4: clk_regs_q[4] <= v;
						default: ;
					endcase
				end
			end
		end
	end

	assign st.kind     = kind;
	assign st.rom_sel  = rom_sel_q;
	assign st.ram_sel  = ram_sel_q;
	assign st.ram_en   = ram_en_q;
	assign st.clk_regs = clk_regs_q;

	// latch arms only on a write transfer leaving the input stage
	`CBC_ASSERT(a_arm_on_write, clk, arst_n, $rose(latch_armed_q) |-> $past(fire && item.mode))

endmodule

### src/cbc_xlate.sv
// Address translation and direct answers for one access.
// Depends on cbc_pkg.
module cbc_xlate import cbc_pkg::*; #(
	parameter int EXT_RAM_BYTES = DEFAULT_EXT_RAM_BYTES
) (
	input  item_t item,
	input  st_t   st,
	output res_t  res
);

	localparam logic [17:0] RAM_LIMIT = 18'(EXT_RAM_BYTES);

	logic [15:0] a;
	logic        in_lo, in_bank, in_ram, mbc2_ok, clk_bank, idx_ok;
	logic [16:0] idx;

	assign a        = item.address;
	assign in_lo    = (a[15:14] == 2'b00);
	assign in_bank  = (a[15:14] == 2'b01);
	assign in_ram   = (a[15:13] == 3'b101);
	assign mbc2_ok  = (a[12:9] == 4'd0);
	assign clk_bank = st.ram_sel inside {[4'd8:4'd12]};
	assign idx      = {st.ram_sel, a[12:0]};
	assign idx_ok   = ({1'b0, idx} < RAM_LIMIT);

	always_comb begin
		res = '0;
		if (!item.mode) begin
			if (in_lo) begin
				res.target      = TGT_ROM;
				res.rom_address = {9'd0, a[13:0]};
			end else if (in_bank) begin
				res.target      = TGT_ROM;
				res.rom_address = {st.rom_sel, a[13:0]};
			end else if (in_ram) begin
				if (st.kind == MT_MBC2) begin
					if (mbc2_ok) begin
						res.target       = TGT_RAM;
						res.ram_address  = {4'd0, a[12:0]};
						res.read_or_mask = MBC2_MASK;
					end else begin
						res.target     = TGT_HERE;
						res.read_value = OPEN_BUS;
					end
				end else if (st.kind == MT_MBC3 && clk_bank) begin
					res.target     = TGT_HERE;
					res.read_value = st.ram_en ? clk_pick(st.clk_regs, st.ram_sel[2:0])
						: OPEN_BUS;
				end else if (idx_ok) begin
					res.target      = TGT_RAM;
					res.ram_address = idx;
				end else begin
					res.target     = TGT_HERE;
					res.read_value = OPEN_BUS;
				end
			end else begin
				res.read_value = OPEN_BUS;
			end
		end else if (in_ram && st.ram_en && st.kind != MT_ROM) begin
			if (st.kind == MT_MBC2) begin
				if (mbc2_ok) begin
					res.target         = TGT_RAM;
					res.ram_address    = {4'd0, a[12:0]};
					res.ram_write      = 1'b1;
					res.ram_write_data = {4'd0, item.write_data[3:0]};
				end
			end else if (st.kind == MT_MBC3 && clk_bank) begin
				res.target = TGT_HERE;
			end else if (idx_ok) begin
				res.target         = TGT_RAM;
				res.ram_address    = idx;
				res.ram_write      = 1'b1;
				res.ram_write_data = item.write_data;
			end
		end
	end

endmodule

### src/cartridge_bank_controller_top.sv
// An accepted access passes through the input register, then the result register, which it
// enters only when that register is free. Throughput: one access per cycle while the receiver
// does not stall; the mapper state is read and updated in the same cycle an access leaves
// the input register, so back-to-back accesses see each other's writes.
// A waiting result does not block intake: the input register fills while the result is held.
// Reset (arst_n low, asynchronous): both stages empty, mapper ROM only, ROM bank 1, RAM bank 0,
// RAM disabled, banking mode 0, latch disarmed, clock registers zero.
`include "assert_macros.svh"
module cartridge_bank_controller_top import cbc_pkg::*; #(
	parameter int EXT_RAM_BYTES = DEFAULT_EXT_RAM_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// access channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [5:0]  now_seconds,
	input  logic [5:0]  now_minutes,
	input  logic [4:0]  now_hours,
	input  logic [15:0] now_days,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  target,
	output logic [22:0] rom_address,
	output logic [16:0] ram_address,
	output logic        ram_write,
	output logic [7:0]  ram_write_data,
	output logic [7:0]  read_value,
	output logic [7:0]  read_or_mask,
	// mapper_type register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	// input stage
	logic       valid_s1;
	item_t      item_s1;
	logic [5:0] sec_s1, min_s1;
	logic [4:0] hrs_s1;
	logic [8:0] days_s1;

	// result stage
	logic out_valid_q;
	res_t res_q;

	st_t  st;
	res_t res;
	logic out_free;   // result register can take a new result this cycle
	logic advance;    // input stage moves to the result register
	logic in_xfer;
	logic res_ram;    // held result targets external RAM
	logic mask_set;   // held result carries a read mask

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;   // write only while idle (not enforced here); always taken

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.mode       <= mode;
			item_s1.address    <= address;
			item_s1.write_data <= write_data;
			sec_s1             <= now_seconds;
			min_s1             <= now_minutes;
			hrs_s1             <= now_hours;
			days_s1            <= now_days[8:0];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	cbc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.fire        (advance),
		.item        (item_s1),
		.now_seconds (sec_s1),
		.now_minutes (min_s1),
		.now_hours   (hrs_s1),
		.now_days    (days_s1),
		.st          (st)
	);

	// translation sees state before this access's own update
	cbc_xlate #(
		.EXT_RAM_BYTES (EXT_RAM_BYTES)
	) u_xlate (
		.item (item_s1),
		.st   (st),
		.res  (res)
	);

	assign out_valid      = out_valid_q;
	assign target         = res_q.target;
	assign rom_address    = res_q.rom_address;
	assign ram_address    = res_q.ram_address;
	assign ram_write      = res_q.ram_write;
	assign ram_write_data = res_q.ram_write_data;
	assign read_value     = res_q.read_value;
	assign read_or_mask   = res_q.read_or_mask;

	assign res_ram  = (res_q.target == TGT_RAM);
	assign mask_set = out_valid_q && (res_q.read_or_mask != 8'd0);

	// a RAM strobe always goes with a RAM target
	`CBC_ASSERT(a_strobe_ram, clk, arst_n, (out_valid_q && res_q.ram_write) |-> res_ram)
	// the read mask only appears on RAM reads
	`CBC_ASSERT(a_mask_ram, clk, arst_n, mask_set |-> (res_ram && !res_q.ram_write))
	// a transfer out of the input stage always fills the result register
	`CBC_ASSERT_MSG(a_adv_fill, clk, arst_n, advance |=> out_valid_q, "result lost after advance")

endmodule

### tb/cartridge_bank_controller_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cartridge_bank_controller_top: bus accesses under every mapper
// kind, checked transfer by transfer against a behavioral mapper predictor kept in this file.
// Depends on cbc_pkg and the RTL of cartridge_bank_controller_top.
module cartridge_bank_controller_top_tb;
	import cbc_pkg::*;

	localparam int RAM_BYTES       = DEFAULT_EXT_RAM_BYTES;
	localparam int RESET_CYCLES    = 11;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 60;    // long receiver stall, fills both stages
	localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on any channel

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// highest mapper code, outside the known kinds
	localparam logic [2:0] MT_TOP_CODE = 3'd7;

	// bus map
	localparam logic [15:0] ENABLE_TOP    = 16'h1FFF;
	localparam logic [15:0] ROM_SEL_BASE  = 16'h2000;
	localparam logic [15:0] MBC5_LOW_TOP  = 16'h2FFF;
	localparam logic [15:0] MBC5_HIGH_SEL = 16'h3000;
	localparam logic [15:0] ROM_FIXED_TOP = 16'h3FFF;
	localparam logic [15:0] RAM_SEL_BASE  = 16'h4000;
	localparam logic [15:0] CTRL_TOP      = 16'h5FFF;
	localparam logic [15:0] LATCH_BASE    = 16'h6000;
	localparam logic [15:0] ROM_BANK_TOP  = 16'h7FFF;
	localparam logic [15:0] RAM_BASE      = 16'hA000;
	localparam logic [15:0] MBC2_RAM_TOP  = 16'hA1FF;
	localparam logic [15:0] RAM_TOP       = 16'hBFFF;
	localparam logic [15:0] MBC2_ROM_SEL  = 16'h0100;  // address bit 8 picks bank select

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [7:0] LATCH_ARM  = 8'h00;
	localparam logic [7:0] LATCH_FIRE = 8'h01;

	// one bus access as driven on the input ports
	typedef struct packed {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [5:0]  now_seconds;
		logic [5:0]  now_minutes;
		logic [4:0]  now_hours;
		logic [15:0] now_days;
	} access_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [5:0]  now_seconds;
	logic [5:0]  now_minutes;
	logic [4:0]  now_hours;
	logic [15:0] now_days;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  target;
	logic [22:0] rom_address;
	logic [16:0] ram_address;
	logic        ram_write;
	logic [7:0]  ram_write_data;
	logic [7:0]  read_value;
	logic [7:0]  read_or_mask;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	cartridge_bank_controller_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mapper state as the predictor sees it. Updated in intake order, so each
	// access is translated with every earlier control write already applied.
	logic [2:0] mdl_mapper;
	logic [8:0] mdl_rom_sel;
	logic [3:0] mdl_ram_sel;
	logic       mdl_ram_on;
	logic       mdl_bank_mode;
	logic       mdl_latch_armed;
	logic [7:0] mdl_rtc [5];

	res_t pending_maps [$];  // translations still waiting for their result transfer
	int   fail_count = 0;
	int   sent_count = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_left = 0;      // receiver hold-off, counted down by the receiver itself

	// Translate one access and apply its side effects on the mapper state.
	function automatic res_t map_access(input access_t a);
		res_t       r;
		logic [2:0] k;
		logic [16:0] bank_idx;
		logic       rtc_bank;
		logic       in_ram;
		logic [2:0] ri;
		logic [7:0] wd;
		r = '0;
		wd = a.write_data;
		// unknown mapper codes fall back to ROM only
		k = (mdl_mapper <= MT_MBC5) ? mdl_mapper : MT_ROM;
		rtc_bank = (mdl_ram_sel >= 4'd8) && (mdl_ram_sel <= 4'd12);
		ri = 3'(mdl_ram_sel - 4'd8);
		bank_idx = {mdl_ram_sel, a.address[12:0]};  // bank * 0x2000 + offset
		in_ram = (a.address >= RAM_BASE) && (a.address <= RAM_TOP);
		if (a.mode == MODE_READ) begin
			if (a.address <= ROM_FIXED_TOP) begin
				r.target = TGT_ROM;
				r.rom_address = 23'(a.address);
			end else if (a.address <= ROM_BANK_TOP) begin
				r.target = TGT_ROM;
				r.rom_address = {mdl_rom_sel, a.address[13:0]};
			end else if (in_ram) begin
				if (k == MT_MBC2) begin
					if (a.address <= MBC2_RAM_TOP) begin
						r.target = TGT_RAM;
						r.ram_address = 17'(a.address[12:0]);
						r.read_or_mask = MBC2_MASK;
					end else begin
						r.target = TGT_HERE;
						r.read_value = OPEN_BUS;
					end
				end else if (k == MT_MBC3 && rtc_bank) begin
					r.target = TGT_HERE;
					r.read_value = mdl_ram_on ? mdl_rtc[ri] : OPEN_BUS;
				end else if (bank_idx < RAM_BYTES) begin
					r.target = TGT_RAM;
					r.ram_address = bank_idx;
				end else begin
					r.target = TGT_HERE;
					r.read_value = OPEN_BUS;
				end
			end else begin
				r.read_value = OPEN_BUS;
			end
		end else if (a.address <= ROM_FIXED_TOP) begin
			if (k == MT_MBC2) begin
				if (a.address[8])
					mdl_rom_sel = (wd[3:0] == 4'd0) ? 9'd1 : 9'(wd[3:0]);
				else
					mdl_ram_on = (wd[3:0] == RAM_EN_KEY);
			end else if (a.address <= ENABLE_TOP) begin
				if (k != MT_ROM)
					mdl_ram_on = (wd[3:0] == RAM_EN_KEY);
			end else if (k == MT_MBC1) begin
				// low five bits; bank bit 8 drops out
				mdl_rom_sel = {1'b0, mdl_rom_sel[7:5], (wd[4:0] == 5'd0) ? 5'd1 : wd[4:0]};
			end else if (k == MT_MBC3) begin
				mdl_rom_sel = (wd[6:0] == 7'd0) ? 9'd1 : 9'(wd[6:0]);
			end else if (k == MT_MBC5) begin
				if (a.address <= MBC5_LOW_TOP)
					mdl_rom_sel = {mdl_rom_sel[8], wd};
				else
					mdl_rom_sel = {wd[0], mdl_rom_sel[7:0]};
			end
		end else if (a.address <= CTRL_TOP) begin
			if (k == MT_MBC1) begin
				if (!mdl_bank_mode)
					mdl_rom_sel = {2'b00, wd[1:0], mdl_rom_sel[4:0]};
				else
					mdl_ram_sel = {2'b00, wd[1:0]};
			end else if (k == MT_MBC3 || k == MT_MBC5) begin
				mdl_ram_sel = wd[3:0];
			end
		end else if (a.address <= ROM_BANK_TOP) begin
			if (k == MT_MBC1) begin
				mdl_bank_mode = wd[0];
			end else if (k == MT_MBC3) begin
				// arm on 0x00, fire on a following 0x01, anything else disarms
				if (!mdl_latch_armed && wd == LATCH_ARM) begin
					mdl_latch_armed = 1'b1;
				end else if (mdl_latch_armed && wd == LATCH_FIRE) begin
					mdl_rtc[0] = {2'b00, a.now_seconds};
					mdl_rtc[1] = {2'b00, a.now_minutes};
					mdl_rtc[2] = {3'b000, a.now_hours};
					mdl_rtc[3] = a.now_days[7:0];
					mdl_rtc[4] = {mdl_rtc[4][7], 6'd0, a.now_days[8]};
					mdl_latch_armed = 1'b0;
				end else begin
					mdl_latch_armed = 1'b0;
				end
			end
		end else if (in_ram && mdl_ram_on && k != MT_ROM) begin
			if (k == MT_MBC2) begin
				if (a.address <= MBC2_RAM_TOP) begin
					r.target = TGT_RAM;
					r.ram_address = 17'(a.address[12:0]);
					r.ram_write = 1'b1;
					r.ram_write_data = {4'd0, wd[3:0]};
				end
			end else if (k == MT_MBC3 && rtc_bank) begin
				mdl_rtc[ri] = wd;
				r.target = TGT_HERE;
			end else if (bank_idx < RAM_BYTES) begin
				r.target = TGT_RAM;
				r.ram_address = bank_idx;
				r.ram_write = 1'b1;
				r.ram_write_data = wd;
			end
		end
		return r;
	endfunction

	// Access with random host time; every time bit gets exercised, ranges ignored.
	function automatic access_t mk_access(input logic m, input logic [15:0] addr,
			input logic [7:0] data);
		access_t a;
		a.mode = m;
		a.address = addr;
		a.write_data = data;
		a.now_seconds = 6'($urandom);
		a.now_minutes = 6'($urandom);
		a.now_hours = 5'($urandom);
		a.now_days = 16'($urandom);
		return a;
	endfunction

	// Offer one access, with random sender gaps, and predict it on its transfer.
	// Valid stays up after the transfer; the next call or drain_results settles it.
	task automatic send_access(input access_t a);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{mode, address, write_data, now_seconds, now_minutes, now_hours, now_days} <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_maps.push_back(map_access(a));
		sent_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
	endtask

	// Mapper register is only written with the block idle.
	task automatic write_mapper(input logic [2:0] m);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mdl_mapper = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- directed tests ----------------

	// Reset state: ROM only, bank 1, RAM reads follow the banked rule, writes dropped.
	task automatic test_rom_only_reset();
		send_access(mk_access(MODE_READ, ROM_BANK_TOP, 8'h00));
		send_access(mk_access(MODE_WRITE, RAM_BASE, 8'h55));
		send_access(mk_access(MODE_READ, RAM_BASE, 8'h00));
		send_access(mk_access(MODE_READ, 16'hFFFF, 8'h00));
	endtask

	// MBC1: zero bank maps to one, upper bank bits, mode switch to RAM banking.
	task automatic test_mbc1_banking();
		write_mapper(MT_MBC1);
		send_access(mk_access(MODE_WRITE, 16'h0000, 8'h0A));
		send_access(mk_access(MODE_WRITE, ROM_SEL_BASE, 8'h00));
		send_access(mk_access(MODE_WRITE, RAM_SEL_BASE, 8'h03));
		send_access(mk_access(MODE_READ, ROM_BANK_TOP, 8'h00));
		send_access(mk_access(MODE_WRITE, LATCH_BASE, 8'h01));
		send_access(mk_access(MODE_WRITE, RAM_SEL_BASE, 8'h03));
		send_access(mk_access(MODE_WRITE, RAM_TOP, 8'hFF));
	endtask

	// MBC2: nibble RAM, zero bank, reads past the 512-byte window.
	task automatic test_mbc2_nibble_ram();
		write_mapper(MT_MBC2);
		send_access(mk_access(MODE_WRITE, MBC2_ROM_SEL, 8'h00));
		send_access(mk_access(MODE_WRITE, 16'h0000, 8'h0A));
		send_access(mk_access(MODE_WRITE, MBC2_RAM_TOP, 8'hFF));
		send_access(mk_access(MODE_READ, MBC2_RAM_TOP + 16'd1, 8'h00));
	endtask

	// MBC3: clock register write, latch with out-of-range time keeping day bit 7,
	// then clock access with RAM disabled.
	task automatic test_mbc3_clock_latch();
		access_t a;
		write_mapper(MT_MBC3);
		send_access(mk_access(MODE_WRITE, 16'h0000, 8'h0A));
		send_access(mk_access(MODE_WRITE, RAM_SEL_BASE, 8'h0C));
		send_access(mk_access(MODE_WRITE, RAM_BASE, 8'hFF));
		send_access(mk_access(MODE_WRITE, LATCH_BASE, LATCH_ARM));
		a = mk_access(MODE_WRITE, ROM_BANK_TOP, LATCH_FIRE);
		a.now_seconds = '1;
		a.now_minutes = '1;
		a.now_hours = '1;
		a.now_days = '1;
		send_access(a);
		send_access(mk_access(MODE_READ, RAM_BASE, 8'h00));
		send_access(mk_access(MODE_WRITE, 16'h0000, 8'h00));
		send_access(mk_access(MODE_WRITE, RAM_TOP, 8'h12));
		send_access(mk_access(MODE_READ, RAM_BASE, 8'h00));
	endtask

	// MBC5: nine-bit ROM bank at its top, RAM bank beyond the array.
	task automatic test_mbc5_wide_bank();
		write_mapper(MT_MBC5);
		send_access(mk_access(MODE_WRITE, ROM_SEL_BASE, 8'hFF));
		send_access(mk_access(MODE_WRITE, MBC5_HIGH_SEL, 8'h01));
		send_access(mk_access(MODE_READ, ROM_BANK_TOP, 8'h00));
		send_access(mk_access(MODE_WRITE, RAM_SEL_BASE, 8'h0F));
		send_access(mk_access(MODE_READ, RAM_TOP, 8'h00));
	endtask

	// Highest mapper code acts as ROM only.
	task automatic test_unknown_mapper();
		write_mapper(MT_TOP_CODE);
		send_access(mk_access(MODE_WRITE, ROM_SEL_BASE, 8'h00));
		send_access(mk_access(MODE_READ, RAM_SEL_BASE, 8'h00));
	endtask

	// Receiver holds off for a long stretch while accesses keep coming: both
	// stages fill and the block has to stall its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = HOLD_OFF_CYCLES;
		repeat (24)
			send_access(mk_access(1'($urandom), 16'($urandom_range(16'h7FFF)),
					8'($urandom)));
	endtask

	// ---------------- random traffic ----------------

	// Every mapper code in turn. Mostly well-formed episodes (enable plus bank
	// selects, latch pairs, RAM window and ROM traffic), some mode writes and noise.
	task automatic test_random_traffic(input int gap_pct, input int hold_pct,
			input int per_mapper);
		int         stop_at;
		int         sel;
		logic [7:0] d;
		logic [15:0] a;
		send_idle_pct = gap_pct;
		stall_pct = hold_pct;
		for (int m = 0; m < 8; m++) begin
			write_mapper(3'(m));
			stop_at = sent_count + per_mapper;
			while (sent_count < stop_at) begin
				sel = $urandom_range(99);
				if (sel < 15) begin
					d = ($urandom_range(9) < 7) ? {4'($urandom), RAM_EN_KEY} : 8'($urandom);
					send_access(mk_access(MODE_WRITE, 16'($urandom_range(ENABLE_TOP)), d));
					send_access(mk_access(MODE_WRITE,
							16'($urandom_range(ROM_FIXED_TOP, ROM_SEL_BASE)), 8'($urandom)));
					d = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
					send_access(mk_access(MODE_WRITE,
							16'($urandom_range(CTRL_TOP, RAM_SEL_BASE)), d));
				end else if (sel < 25) begin
					send_access(mk_access(MODE_WRITE,
							16'($urandom_range(ROM_BANK_TOP, LATCH_BASE)), LATCH_ARM));
					d = ($urandom_range(9) < 8) ? LATCH_FIRE : 8'($urandom);
					send_access(mk_access(MODE_WRITE,
							16'($urandom_range(ROM_BANK_TOP, LATCH_BASE)), d));
				end else if (sel < 60) begin
					// external RAM window, biased toward the MBC2 nibble range
					if ($urandom_range(9) < 4)
						a = 16'($urandom_range(MBC2_RAM_TOP, RAM_BASE));
					else
						a = 16'($urandom_range(RAM_TOP, RAM_BASE));
					send_access(mk_access(1'($urandom), a, 8'($urandom)));
				end else if (sel < 80) begin
					send_access(mk_access(MODE_READ, 16'($urandom_range(ROM_BANK_TOP)),
							8'($urandom)));
				end else if (sel < 88) begin
					send_access(mk_access(MODE_WRITE,
							16'($urandom_range(ROM_BANK_TOP, LATCH_BASE)), 8'($urandom)));
				end else begin
					send_access(mk_access(1'($urandom), 16'($urandom), 8'($urandom)));
				end
			end
		end
	endtask

	// ---------------- receiver, checker, watchdog ----------------

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [22:0] want,
			input logic [22:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_maps.size() == 0) begin
				$error("result transfer with no access outstanding");
				fail_count++;
			end else begin
				want = pending_maps.pop_front();
				check_field("target", 23'(want.target), 23'(target));
				check_field("rom_address", want.rom_address, rom_address);
				check_field("ram_address", 23'(want.ram_address), 23'(ram_address));
				check_field("ram_write", 23'(want.ram_write), 23'(ram_write));
				check_field("ram_write_data", 23'(want.ram_write_data), 23'(ram_write_data));
				check_field("read_value", 23'(want.read_value), 23'(read_value));
				check_field("read_or_mask", 23'(want.read_or_mask), 23'(read_or_mask));
			end
		end
	end

	// Any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		{mode, address, write_data, now_seconds, now_minutes, now_hours, now_days} = '0;
		cfg_valid = 1'b0;
		cfg_data = MT_ROM;
		mdl_mapper = MT_ROM;
		mdl_rom_sel = 9'd1;
		mdl_ram_sel = 4'd0;
		mdl_ram_on = 1'b0;
		mdl_bank_mode = 1'b0;
		mdl_latch_armed = 1'b0;
		for (int i = 0; i < 5; i++)
			mdl_rtc[i] = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_rom_only_reset();
		test_mbc1_banking();
		test_mbc2_nibble_ram();
		test_mbc3_clock_latch();
		test_mbc5_wide_bank();
		test_unknown_mapper();
		test_backpressure();
		test_random_traffic(0, 0, 45);
		test_random_traffic(62, 0, 45);
		test_random_traffic(0, 62, 45);
		test_random_traffic(21, 21, 46);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/cbc_pkg.sv
src/cbc_state.sv
src/cbc_xlate.sv
src/cartridge_bank_controller_top.sv
tb/cartridge_bank_controller_top_tb.sv
